[src/aar_pkg.sv]
// Shared types, constants and helpers for the axis-angle rotation matrix block.
// Used by aar_prep, aar_cordic, aar_matrix and the top level; no dependencies.
package aar_pkg;

  // Stage counts of the fixed parts of the datapath
  localparam int PREP_LAT = 4;
  localparam int SQRT_LAT = 32;
  localparam int DIV_LAT  = 31;
  localparam int AXIS_LAT = PREP_LAT + SQRT_LAT + DIV_LAT;
  localparam int MAT_LAT  = 7;
  localparam int PIPE_LAT = AXIS_LAT + MAT_LAT;

  // CORDIC vector width, Q2.30 with headroom
  localparam int CS_W = 34;
  localparam logic signed [CS_W-1:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [31:0]     ONE_Q16  = 32'sd65536;

  localparam logic [31:0] ATAN_TAB [0:29] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t col0;
    q16_t col1;
    q16_t col2;
    q16_t col3;
  } row_t;

  typedef row_t [2:0] rows_t;

  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/axis_angle_rotation_matrix.sv]
// Rotation about an arbitrary axis line, as a 4x4 homogeneous matrix in four row transfers.
// Rows of a loaded matrix follow one per cycle while out_stall is low.
// Throughput is set by the four-row output register, which holds one matrix at a time; the
// 74-stage pipeline under one shared enable accepts an item in any cycle it moves.
// Reset (rst, synchronous) clears the valid line, out_valid and the row count only.
// Uses aar_pkg and the aar_* modules.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  aar_pkg::q16_t       point_x,
  input  aar_pkg::q16_t       point_y,
  input  aar_pkg::q16_t       point_z,
  input  aar_pkg::q16_t       axis_x,
  input  aar_pkg::q16_t       axis_y,
  input  aar_pkg::q16_t       axis_z,
  input  logic signed [15:0]  angle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          row_index,
  output aar_pkg::q16_t       col0,
  output aar_pkg::q16_t       col1,
  output aar_pkg::q16_t       col2,
  output aar_pkg::q16_t       col3,
  output logic                last_row
);
  import aar_pkg::*;

  localparam int CS_DLY = AXIS_LAT - CORDIC_STAGES - 1;
  localparam int SIDE_W = 3 * 32 + 3 + 1;

  logic                en;
  logic [PIPE_LAT-1:0] vld;
  logic                take, load_ok, load;

  logic [63:0]         sum;
  logic [2:0][31:0]    m_prep, m_div;
  logic [31:0]         len;
  logic [2:0][30:0]    quo;
  logic signed [CS_W-1:0] c_raw, s_raw, c_al, s_al;
  logic [SIDE_W-1:0]   side_in, side_out;
  q16_t [2:0]          p_al;
  logic [2:0]          neg_al;
  logic                zero_al;
  rows_t               mat, rows;
  logic [1:0]          row;

  // pipeline moves unless a finished matrix is waiting on the output register
  assign take    = out_valid && !out_stall;
  assign load_ok = !out_valid || (take && row == 2'd3);
  assign en      = load_ok || !vld[PIPE_LAT-1];
  assign load    = vld[PIPE_LAT-1] && load_ok;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  assign side_in = {point_x, point_y, point_z, axis_z[31], axis_y[31], axis_x[31],
                    (axis_x == 32'sd0) && (axis_y == 32'sd0) && (axis_z == 32'sd0)};

  aar_prep u_prep (
    .clk (clk), .en (en), .ax (axis_x), .ay (axis_y), .az (axis_z),
    .sum (sum), .m (m_prep)
  );

  aar_sqrt u_sqrt (.clk (clk), .en (en), .v (sum), .root (len));

  aar_delay #(.WIDTH (96), .DEPTH (SQRT_LAT)) u_m_dly (
    .clk (clk), .en (en), .d (m_prep), .q (m_div)
  );

  aar_div u_div (.clk (clk), .en (en), .m (m_div), .len (len), .q (quo));

  aar_cordic #(.STAGES (CORDIC_STAGES)) u_cordic (
    .clk (clk), .en (en), .opcode (opcode), .angle (angle), .c (c_raw), .s (s_raw)
  );

  aar_delay #(.WIDTH (2 * CS_W), .DEPTH (CS_DLY)) u_cs_dly (
    .clk (clk), .en (en), .d ({c_raw, s_raw}), .q ({c_al, s_al})
  );

  aar_delay #(.WIDTH (SIDE_W), .DEPTH (AXIS_LAT)) u_side_dly (
    .clk (clk), .en (en), .d (side_in), .q (side_out)
  );

  assign p_al[0] = side_out[SIDE_W-1 -: 32];
  assign p_al[1] = side_out[SIDE_W-33 -: 32];
  assign p_al[2] = side_out[SIDE_W-65 -: 32];
  assign neg_al  = side_out[3:1];
  assign zero_al = side_out[0];

  aar_matrix u_matrix (
    .clk (clk), .en (en), .q (quo), .neg (neg_al), .zero (zero_al),
    .c (c_al), .s (s_al), .p (p_al), .rows (mat)
  );

  // output register: holds one matrix and sends it row by row
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      row       <= 2'd0;
    end else if (take) begin
      if (row == 2'd3) begin
        out_valid <= 1'b0;
      end else begin
        row <= row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rows <= mat;
    end
  end

  assign row_index = row;
  assign last_row  = (row == 2'd3);

  always_comb begin
    case (row)
      2'd0: begin
        col0 = rows[0].col0; col1 = rows[0].col1;
        col2 = rows[0].col2; col3 = rows[0].col3;
      end
      2'd1: begin
        col0 = rows[1].col0; col1 = rows[1].col1;
        col2 = rows[1].col2; col3 = rows[1].col3;
      end
      2'd2: begin
        col0 = rows[2].col0; col1 = rows[2].col1;
        col2 = rows[2].col2; col3 = rows[2].col3;
      end
      default: begin
        col0 = '0; col1 = '0; col2 = '0; col3 = ONE_Q16;
      end
    endcase
  end

endmodule

[src/aar_delay.sv]
// Enable-gated register line that keeps side data aligned with the datapath.
// No package dependencies.
module aar_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

[src/aar_prep.sv]
// Axis preparation: magnitudes, common normalizing shift, squares and their sum.
// Four register stages; uses aar_pkg types.
module aar_prep (
  input  logic                clk,
  input  logic                en,
  input  aar_pkg::q16_t       ax,
  input  aar_pkg::q16_t       ay,
  input  aar_pkg::q16_t       az,
  output logic [63:0]         sum,
  output logic [2:0][31:0]    m
);
  import aar_pkg::*;

  logic [2:0][31:0] m1, m2, m3;
  logic [2:0][63:0] sq3;
  logic [31:0]      mx;
  logic [4:0]       sh;
  q16_t             a [3];

  assign a[0] = ax;
  assign a[1] = ay;
  assign a[2] = az;

  always_comb begin
    mx = m1[0];
    if (m1[1] > mx) mx = m1[1];
    if (m1[2] > mx) mx = m1[2];
    // shift that brings the largest magnitude to at least 2^30
    sh = 5'd0;
    for (int b = 0; b < 31; b++) begin
      if (mx[b]) sh = 5'(30 - b);
    end
    if (mx[31]) sh = 5'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i]  <= a[i][31] ? 32'(-a[i]) : 32'(a[i]);
        m2[i]  <= m1[i] << sh;
        sq3[i] <= {32'd0, m2[i]} * {32'd0, m2[i]};
        m3[i]  <= m2[i];
        m[i]   <= m3[i];
      end
      sum <= sq3[0] + sq3[1] + sq3[2];
    end
  end

endmodule

[src/aar_sqrt.sv]
// Pipelined integer square root, one result bit per stage (32 stages).
// Digit-by-digit remainder method; no package dependencies.
module aar_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v,
  output logic [31:0] root
);

  logic [31:0] root_q [1:32];
  logic [35:0] rem_q  [1:32];
  logic [63:0] v_q    [1:32];

  for (genvar s = 0; s < 32; s++) begin : g_st
    logic [31:0] r_i;
    logic [35:0] rem_i;
    logic [63:0] v_i;
    logic [35:0] acc, trial;

    if (s == 0) begin : g_first
      assign r_i   = '0;
      assign rem_i = '0;
      assign v_i   = v;
    end else begin : g_rest
      assign r_i   = root_q[s];
      assign rem_i = rem_q[s];
      assign v_i   = v_q[s];
    end

    assign acc   = {rem_i[33:0], v_i[63-2*s -: 2]};
    assign trial = {2'b00, r_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[s+1] <= v_i;
        if (acc >= trial) begin
          rem_q[s+1]  <= acc - trial;
          root_q[s+1] <= {r_i[30:0], 1'b1};
        end else begin
          rem_q[s+1]  <= acc;
          root_q[s+1] <= {r_i[30:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[32];

endmodule

[src/aar_div.sv]
// Three-lane pipelined restoring divider: q = round(m * 2^30 / len).
// One quotient bit per stage, 31 stages; no package dependencies.
module aar_div (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][31:0] m,
  input  logic [31:0]      len,
  output logic [2:0][30:0] q
);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [32:0] rem_q [1:31];
    logic [30:0] quo_q [1:31];
    logic [30:0] n_q   [1:31];
    logic [31:0] len_q [1:31];

    for (genvar s = 0; s < 31; s++) begin : g_st
      logic [32:0] rem_i;
      logic [30:0] quo_i;
      logic [30:0] n_i;
      logic [31:0] len_i;
      logic [32:0] acc;

      if (s == 0) begin : g_first
        logic [62:0] nfull;
        // numerator with half divisor added for rounding
        assign nfull = {1'b0, m[l], 30'd0} + {32'd0, len[31:1]};
        assign rem_i = {1'b0, nfull[62:31]};
        assign quo_i = '0;
        assign n_i   = nfull[30:0];
        assign len_i = len;
      end else begin : g_rest
        assign rem_i = rem_q[s];
        assign quo_i = quo_q[s];
        assign n_i   = n_q[s];
        assign len_i = len_q[s];
      end

      assign acc = {rem_i[31:0], n_i[30-s]};

      always_ff @(posedge clk) begin
        if (en) begin
          n_q[s+1]   <= n_i;
          len_q[s+1] <= len_i;
          if (acc >= {1'b0, len_i}) begin
            rem_q[s+1] <= acc - {1'b0, len_i};
            quo_q[s+1] <= {quo_i[29:0], 1'b1};
          end else begin
            rem_q[s+1] <= acc;
            quo_q[s+1] <= {quo_i[29:0], 1'b0};
          end
        end
      end
    end

    assign q[l] = quo_q[31];
  end

endmodule

[src/aar_cordic.sv]
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30.
// One quadrant stage plus STAGES micro-rotation stages; uses aar_pkg constants.
module aar_cordic #(
  parameter int STAGES = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic                               opcode,
  input  logic signed [15:0]                 angle,
  output logic signed [aar_pkg::CS_W-1:0]    c,
  output logic signed [aar_pkg::CS_W-1:0]    s
);
  import aar_pkg::*;

  logic signed [CS_W-1:0] x_q [0:STAGES];
  logic signed [CS_W-1:0] y_q [0:STAGES];
  logic signed [32:0]     z_q [0:STAGES];

  logic signed [15:0] ang_n;
  logic signed [16:0] zq;
  logic signed [CS_W-1:0] x0, y0;

  always_comb begin
    // inverse: negate, wrapping in 16 bits
    ang_n = opcode ? 16'(-angle) : angle;
    if (ang_n >= 16'sd16384) begin
      x0 = '0;
      y0 = GAIN_INV;
      zq = 17'(ang_n) - 17'sd16384;
    end else if (ang_n < -16'sd16384) begin
      x0 = '0;
      y0 = -GAIN_INV;
      zq = 17'(ang_n) + 17'sd16384;
    end else begin
      x0 = GAIN_INV;
      y0 = '0;
      zq = 17'(ang_n);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      z_q[0] <= {zq, 16'd0};
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    logic signed [32:0] at;
    assign at = $signed({1'b0, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign c = x_q[STAGES];
  assign s = y_q[STAGES];

endmodule

[src/aar_matrix.sv]
// Matrix assembly: unit axis, R = cI + s[k]x + (1-c)kk^T, translation p - Rp,
// rounding and saturation to Q16.16. Seven register stages; uses aar_pkg.
module aar_matrix (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2:0][30:0]                q,
  input  logic [2:0]                      neg,
  input  logic                            zero,
  input  logic signed [aar_pkg::CS_W-1:0] c,
  input  logic signed [aar_pkg::CS_W-1:0] s,
  input  aar_pkg::q16_t [2:0]             p,
  output aar_pkg::rows_t                  rows
);
  import aar_pkg::*;

  localparam int KI [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
  localparam int KA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int KB [6] = '{0, 1, 2, 1, 2, 2};

  // stage 0
  logic signed [31:0]     k0 [3];
  logic signed [CS_W-1:0] c0, s0;
  q16_t [2:0]             p0;
  // stage 1
  logic signed [31:0]     kk1 [6];
  logic signed [35:0]     sk1 [3];
  logic signed [34:0]     omc1;
  logic signed [CS_W-1:0] c1;
  q16_t [2:0]             p1;
  // stage 2
  logic signed [35:0]     t2 [6];
  logic signed [35:0]     sk2 [3];
  logic signed [CS_W-1:0] c2;
  q16_t [2:0]             p2;
  // stage 3
  logic signed [35:0]     r3 [3][3];
  logic signed [35:0]     r3_next [3][3];
  q16_t [2:0]             p3;
  // stage 4
  logic signed [51:0]     pr4 [3][3];
  q16_t                   e4 [3][3];
  q16_t [2:0]             p4;
  // stage 5
  logic signed [53:0]     acc5 [3];
  q16_t                   e5 [3][3];

  logic signed [63:0] pkk [6];
  logic signed [65:0] psk [3];
  logic signed [66:0] pt  [6];
  logic signed [67:0] prp [3][3];
  logic signed [35:0] rr  [3][3];
  logic signed [53:0] ar  [3];

  always_comb begin
    for (int n = 0; n < 6; n++) begin
      pkk[n] = 64'(k0[KA[n]]) * 64'(k0[KB[n]]);
      pt[n]  = 67'(kk1[n]) * 67'(omc1);
    end
    for (int i = 0; i < 3; i++) begin
      psk[i] = 66'(s0) * 66'(k0[i]);
      for (int j = 0; j < 3; j++) begin
        r3_next[i][j] = t2[KI[i][j]] + ((i == j) ? 36'(c2) : 36'sd0);
        prp[i][j]     = 68'(r3[i][j]) * 68'(p3[j]);
        rr[i][j]      = (r3[i][j] + 36'sd8192) >>> 14;
      end
      ar[i] = (acc5[i] + 54'sd8192) >>> 14;
    end
    r3_next[0][1] = r3_next[0][1] - sk2[2];
    r3_next[0][2] = r3_next[0][2] + sk2[1];
    r3_next[1][0] = r3_next[1][0] + sk2[2];
    r3_next[1][2] = r3_next[1][2] - sk2[0];
    r3_next[2][0] = r3_next[2][0] - sk2[1];
    r3_next[2][1] = r3_next[2][1] + sk2[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // unit axis in Q2.30; zero axis stands for +x
      for (int i = 0; i < 3; i++) begin
        if (zero) begin
          k0[i] <= (i == 0) ? 32'sd1073741824 : 32'sd0;
        end else if (neg[i]) begin
          k0[i] <= -$signed({1'b0, q[i]});
        end else begin
          k0[i] <= $signed({1'b0, q[i]});
        end
      end
      c0 <= c;
      s0 <= s;
      p0 <= p;

      for (int n = 0; n < 6; n++) begin
        kk1[n] <= 32'((pkk[n] + 64'sd536870912) >>> 30);
      end
      for (int i = 0; i < 3; i++) begin
        sk1[i] <= 36'((psk[i] + 66'sd536870912) >>> 30);
      end
      omc1 <= 35'sd1073741824 - 35'(c0);
      c1   <= c0;
      p1   <= p0;

      for (int n = 0; n < 6; n++) begin
        t2[n] <= 36'((pt[n] + 67'sd536870912) >>> 30);
      end
      sk2 <= sk1;
      c2  <= c1;
      p2  <= p1;

      r3 <= r3_next;
      p3 <= p2;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr4[i][j] <= 52'(prp[i][j] >>> 16);
          e4[i][j]  <= sat32(64'(rr[i][j]));
        end
      end
      p4 <= p3;

      for (int i = 0; i < 3; i++) begin
        acc5[i] <= (54'(p4[i]) <<< 14) - 54'(pr4[i][0]) - 54'(pr4[i][1])
                   - 54'(pr4[i][2]);
      end
      e5 <= e4;

      for (int i = 0; i < 3; i++) begin
        rows[i].col0 <= e5[i][0];
        rows[i].col1 <= e5[i][1];
        rows[i].col2 <= e5[i][2];
        rows[i].col3 <= sat32(64'(ar[i]));
      end
    end
  end

endmodule

[sim/tb.sv]
// Self-checking testbench for axis_angle_rotation_matrix: drives random and corner transfers,
// predicts the four matrix rows in fixed point and compares every output field.
// Depends on src/aar_pkg.sv and the RTL under src/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aar_pkg::*;

  localparam int  STAGES   = 16;
  localparam int  IDLE_MAX = 4000;
  localparam bit  OP_FWD   = 1'b0;
  localparam bit  OP_INV   = 1'b1;
  localparam longint Q30   = 64'sd1 << 30;
  localparam longint GINV  = 64'sd652032874;
  localparam longint ATAN [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1
  };

  typedef struct {
    logic [1:0] idx;
    q16_t       c0, c1, c2, c3;
    logic       last;
  } mrow_t;

  class rot_matrix_sb;
    mrow_t rows_q[$];
    int    errors;

    static function longint rshr(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    static function q16_t clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return q16_t'(v);
    endfunction

    static function longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // builds the matrix and queues its four rows
    function void note(bit op, q16_t px, q16_t py, q16_t pz,
                       q16_t ax, q16_t ay, q16_t az, logic signed [15:0] ang);
      longint p[3], a[3], k[3], rm[3][3], sk[3];
      longint unsigned m[3], mx, sum, len;
      longint x, y, z, dx, dy, c, s, omc, acc;
      logic signed [15:0] eff;
      mrow_t r;
      p = '{longint'(px), longint'(py), longint'(pz)};
      a = '{longint'(ax), longint'(ay), longint'(az)};
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        k = '{Q30, 0, 0};
      end else begin
        while (mx < (64'd1 << 30)) begin
          mx <<= 1;
          for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
          k[i] = longint'(((m[i] << 30) + (len >> 1)) / len);
          if (a[i] < 0) k[i] = -k[i];
        end
      end
      eff = (op == OP_INV) ? 16'(-ang) : ang;
      x = GINV; y = 0; z = longint'(eff) * 65536;
      if (z >= Q30) begin
        x = 0; y = GINV; z -= Q30;
      end else if (z < -Q30) begin
        x = 0; y = -GINV; z += Q30;
      end
      for (int i = 0; i < STAGES && i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN[i];
        end else begin
          x += dx; y -= dy; z += ATAN[i];
        end
      end
      c = x; s = y;
      omc = Q30 - c;
      for (int i = 0; i < 3; i++) sk[i] = rshr(s * k[i], 30);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          rm[i][j] = ((i == j) ? c : 0) + rshr(rshr(k[i] * k[j], 30) * omc, 30);
      rm[0][1] -= sk[2]; rm[0][2] += sk[1];
      rm[1][0] += sk[2]; rm[1][2] -= sk[0];
      rm[2][0] -= sk[1]; rm[2][1] += sk[0];
      for (int i = 0; i < 3; i++) begin
        acc = p[i] * 16384;
        for (int j = 0; j < 3; j++) acc -= (rm[i][j] * p[j]) >>> 16;
        r.idx  = 2'(i);
        r.c0   = clamp32(rshr(rm[i][0], 14));
        r.c1   = clamp32(rshr(rm[i][1], 14));
        r.c2   = clamp32(rshr(rm[i][2], 14));
        r.c3   = clamp32((acc + 8192) >>> 14);
        r.last = 1'b0;
        rows_q.push_back(r);
      end
      r = '{2'd3, 0, 0, 0, ONE_Q16, 1'b1};
      rows_q.push_back(r);
    endfunction

    function void check(mrow_t got);
      mrow_t e;
      if (rows_q.size() == 0) begin
        $error("unexpected row transfer, row_index %0d", got.idx);
        errors++;
        return;
      end
      e = rows_q.pop_front();
      if (got.idx !== e.idx) begin
        $error("row_index exp %0d got %0d", e.idx, got.idx); errors++;
      end
      if (got.c0 !== e.c0) begin
        $error("col0 exp %0d got %0d", e.c0, got.c0); errors++;
      end
      if (got.c1 !== e.c1) begin
        $error("col1 exp %0d got %0d", e.c1, got.c1); errors++;
      end
      if (got.c2 !== e.c2) begin
        $error("col2 exp %0d got %0d", e.c2, got.c2); errors++;
      end
      if (got.c3 !== e.c3) begin
        $error("col3 exp %0d got %0d", e.c3, got.c3); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_row exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall, opcode = 1'b0;
  q16_t point_x = 0, point_y = 0, point_z = 0, axis_x = 0, axis_y = 0, axis_z = 0;
  logic signed [15:0] angle = 0;
  logic out_valid, out_stall = 1'b0, last_row;
  logic [1:0] row_index;
  q16_t col0, col1, col2, col3;

  rot_matrix_sb sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;

  always #10 clk = ~clk;

  axis_angle_rotation_matrix #(.CORDIC_STAGES(STAGES)) dut (
    .clk, .rst, .in_valid, .in_stall, .opcode, .point_x, .point_y, .point_z,
    .axis_x, .axis_y, .axis_z, .angle, .out_valid, .out_stall, .row_index,
    .col0, .col1, .col2, .col3, .last_row
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{row_index, col0, col1, col2, col3, last_row});
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern: free, light or heavy, switching at random
  always @(negedge clk) begin
    if ($urandom_range(47) == 0) stall_mode = $urandom_range(2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 25);
      default: out_stall <= ($urandom_range(99) < 75);
    endcase
  end

  // presents one item and holds it until the transfer; valid stays high afterwards
  task automatic send(bit op, q16_t px, q16_t py, q16_t pz,
                      q16_t ax, q16_t ay, q16_t az, logic signed [15:0] ang);
    in_valid = 1'b1;
    opcode = op;
    point_x = px; point_y = py; point_z = pz;
    axis_x = ax; axis_y = ay; axis_z = az;
    angle = ang;
    do @(posedge clk); while (in_stall);
    sb.note(op, px, py, pz, ax, ay, az, ang);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic q16_t pick_point();
    case ($urandom_range(3))
      0, 1: return q16_t'($urandom_range(0, 2**22)) - 32'sd2097152;
      2: return q16_t'($urandom);
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic q16_t pick_axis();
    case ($urandom_range(5))
      0: return 0;
      1: return q16_t'($urandom_range(0, 2**18)) - 32'sd131072;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return q16_t'($urandom);
    endcase
  endfunction

  initial begin
    q16_t mx, mn;
    int burst;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // corners: zero axis, unit axes, field extremes, quadrant boundaries
    send(OP_FWD, 0, 0, 0, 0, 0, 0, 16'sd8192);
    send(OP_INV, ONE_Q16, 0, 0, 0, 0, 0, 16'sd8192);
    send(OP_FWD, 0, ONE_Q16, 0, ONE_Q16, 0, 0, 16'sd16384);
    send(OP_FWD, ONE_Q16, 0, 0, 0, ONE_Q16, 0, -16'sd16384);
    send(OP_FWD, ONE_Q16, ONE_Q16, 0, 0, 0, ONE_Q16, 16'sd16383);
    send(OP_FWD, 0, 0, 0, 0, 0, -ONE_Q16, -16'sd16385);
    send(OP_FWD, mx, mx, mx, mx, mx, mx, 16'sh7fff);
    send(OP_INV, mn, mn, mn, mn, mn, mn, 16'sh8000);
    send(OP_FWD, mn, mx, mn, mn, 0, 0, 16'sh8000);
    send(OP_INV, mx, mn, mx, 1, 1, 1, 16'sh7fff);
    send(OP_FWD, mx, mx, mx, 1, 0, 0, 0);
    send(OP_INV, mn, mn, mn, 0, 0, 1, 0);
    send(OP_FWD, 32'sh12345678, -32'sh0fedcba9, 32'sh00010000, 3, -5, 7, 16'sd1);
    send(OP_INV, -ONE_Q16, ONE_Q16, -ONE_Q16, mx, mn, 1, -16'sd1);
    send(OP_FWD, 0, 0, 0, -1, -1, -1, 16'sd10923);
    send(OP_INV, 32'sh7fff0000, 0, 32'sh80010000, 0, mn, 0, 16'sd4096);
    send(OP_FWD, 32'sh00008000, 32'sh00004000, 32'sh00002000, 2, 2, 1, -16'sd24576);
    pause(4);

    for (int n = 0; n < 360; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && n < 360; b++, n++) begin
        send(bit'($urandom_range(1)), pick_point(), pick_point(), pick_point(),
             pick_axis(), pick_axis(), pick_axis(), 16'($urandom));
        if (n == 180) begin
          in_valid = 1'b0;
          while (sb.rows_q.size() != 0) @(negedge clk);
        end
      end
      if ($urandom_range(3) != 0) pause($urandom_range(0, 6));
    end
    in_valid = 1'b0;

    while (sb.rows_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[files.f]
src/aar_pkg.sv
src/aar_delay.sv
src/aar_prep.sv
src/aar_sqrt.sv
src/aar_div.sv
src/aar_cordic.sv
src/aar_matrix.sv
src/axis_angle_rotation_matrix.sv
sim/tb.sv
